// ----- sv/tcg_pkg.sv -----
`default_nettype none
package tcg_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int SLOPE_FRAC_BITS = 16;

    localparam int OUT_C_W  = 24;
    localparam int AREA_W   = 53;
    localparam int SLOPE_W  = 32;
    localparam int LIMIT_W  = 32;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 2;

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DET_W    = PROD_W + 1;
    localparam int REM_W    = DET_W + 1;
    localparam int QW       = SLOPE_W - 1;
    localparam int OVF_SH   = QW - SLOPE_FRAC_BITS;
    localparam int DIV_LAT  = QW + 1;

    // corner sums and divide-by-three reciprocal
    localparam int SUM_W    = COORD_WIDTH + 2;
    localparam int RECIP_K  = COORD_WIDTH + 3;
    localparam int RECIP_W  = RECIP_K;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_K) / 3 + 64'd1);

    localparam logic [PADDR_W-1:0] ADDR_LIMIT  = '0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);
    localparam logic [AREA_W-1:0]  AREA_MAX    = '1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_a;
        logic signed [COORD_WIDTH-1:0] y_a;
        logic signed [COORD_WIDTH-1:0] z_a;
        logic signed [COORD_WIDTH-1:0] x_b;
        logic signed [COORD_WIDTH-1:0] y_b;
        logic signed [COORD_WIDTH-1:0] z_b;
        logic signed [COORD_WIDTH-1:0] x_c;
        logic signed [COORD_WIDTH-1:0] y_c;
        logic signed [COORD_WIDTH-1:0] z_c;
    } t_cell;

    typedef struct packed {
        logic        [AREA_W-1:0]  area;
        logic signed [OUT_C_W-1:0] centroid_x;
        logic signed [OUT_C_W-1:0] centroid_y;
        logic signed [OUT_C_W-1:0] bed_mean;
        logic signed [SLOPE_W-1:0] slope_x;
        logic signed [SLOPE_W-1:0] slope_y;
        logic                      degenerate;
    } t_res;

    // values carried alongside the slope dividers
    typedef struct packed {
        logic        [AREA_W-1:0]  area;
        logic signed [OUT_C_W-1:0] cx;
        logic signed [OUT_C_W-1:0] cy;
        logic signed [OUT_C_W-1:0] bm;
        logic                      deg;
        logic                      neg_x;
        logic                      neg_y;
    } t_side;

    function automatic logic signed [OUT_C_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [63:0] w;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        w  = 64'(v);
        hi = (64'sd1 <<< (OUT_C_W - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (OUT_C_W - 1));
        if (w > hi) begin
            sat_coord = OUT_C_W'(hi);
        end else if (w < lo) begin
            sat_coord = OUT_C_W'(lo);
        end else begin
            sat_coord = OUT_C_W'(w);
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/tcg_chan_if.sv -----
`default_nettype none
interface tcg_in_if;
    logic           valid;
    logic           ready;
    tcg_pkg::t_cell data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcg_out_if;
    logic          valid;
    logic          ready;
    tcg_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/tcg_div.sv -----
`default_nettype none
// Pipelined restoring divider: quotient of num * 2^F / den, one bit per stage.
// o_ovf flags a quotient of 2^QW or more; o_quot is exact otherwise.
module tcg_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [tcg_pkg::DET_W-1:0]  i_num,
    input  wire logic [tcg_pkg::DET_W-1:0]  i_den,
    output logic      [tcg_pkg::QW-1:0]     o_quot,
    output logic                            o_ovf
);
    localparam int DW = tcg_pkg::DET_W;
    localparam int RW = tcg_pkg::REM_W;
    localparam int Q  = tcg_pkg::QW;
    localparam int F  = tcg_pkg::SLOPE_FRAC_BITS;
    localparam int NW = DW + F;

    logic [RW-1:0] r_rem  [Q+1];
    logic [Q-1:0]  r_low  [Q+1];
    logic [Q-1:0]  r_quot [Q+1];
    logic [DW-1:0] r_den  [Q+1];
    logic          r_ovf  [Q+1];

    logic [NW-1:0] n_full;
    logic          n_ovf0;

    always_comb begin
        n_full = {i_num, {F{1'b0}}};
        n_ovf0 = (NW'(i_num) >= (NW'(i_den) << tcg_pkg::OVF_SH));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'(n_full[NW-1:Q]);
            r_low[0]  <= n_full[Q-1:0];
            r_quot[0] <= '0;
            r_den[0]  <= i_den;
            r_ovf[0]  <= n_ovf0;
        end
    end

    for (genvar k = 1; k <= Q; k++) begin : g_step
        logic [RW-1:0] n_trial;
        logic          n_ge;
        always_comb begin
            n_trial = {r_rem[k-1][RW-2:0], r_low[k-1][Q-1]};
            n_ge    = n_trial >= RW'(r_den[k-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_trial - RW'(r_den[k-1]) : n_trial;
                r_low[k]  <= r_low[k-1] << 1;
                r_quot[k] <= {r_quot[k-1][Q-2:0], n_ge};
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_quot[Q];
    assign o_ovf  = r_ovf[Q];

endmodule
`default_nettype wire

// ----- sv/triangle_cell_geometry.sv -----
`default_nettype none
// Triangle cell geometry: area, centroid, mean bed elevation and planar bed
// gradient of one triangle per item. Fully pipelined: a new item is accepted
// every cycle unless the output stalls; it passes through the difference,
// product and determinant registers, one divider setup stage, 31 stages of
// the restoring slope dividers and one output register. A stalled output
// freezes the whole pipeline; i_cell.ready is low only while the output
// register holds an item that is not taken. A cell whose area is zero or below
// the degenerate_area_limit register (APB byte address 0, reset 1) reports
// corner 0 as centroid and elevation and zero slopes.
module triangle_cell_geometry (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    tcg_in_if.sink                            i_cell,
    tcg_out_if.source                         o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tcg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcg_pkg::APB_DW-1:0]   pwdata,
    output logic      [tcg_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    localparam int CW = tcg_pkg::COORD_WIDTH;
    localparam int DF = tcg_pkg::DIFF_W;
    localparam int PW = tcg_pkg::PROD_W;
    localparam int DW = tcg_pkg::DET_W;
    localparam int SW = tcg_pkg::SUM_W;
    localparam int RK = tcg_pkg::RECIP_K;
    localparam int ML = tcg_pkg::DIV_LAT;
    localparam int SL = tcg_pkg::SLOPE_W;

    logic en;
    logic [tcg_pkg::LIMIT_W-1:0] r_limit;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == tcg_pkg::ADDR_LIMIT) ? tcg_pkg::APB_DW'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tcg_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == tcg_pkg::ADDR_LIMIT) begin
            r_limit <= tcg_pkg::LIMIT_W'(pwdata);
        end
    end

    // ---------------- pipeline control ----------------
    logic          r_v1, r_v2, r_v3, r_vout;
    logic [ML-1:0] r_vsb;

    assign en           = !r_vout || o_res.ready;
    assign i_cell.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vsb  <= '0;
            r_vout <= 1'b0;
        end else if (en) begin
            r_v1   <= i_cell.valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_vsb  <= {r_vsb[ML-2:0], r_v3};
            r_vout <= r_vsb[ML-1];
        end
    end

    // ---------------- stage 1: edge vectors and corner sums ----------------
    logic signed [DF-1:0] r_s1_dxb, r_s1_dyb, r_s1_dzb, r_s1_dxc, r_s1_dyc, r_s1_dzc;
    logic signed [SW-1:0] r_s1_sx, r_s1_sy, r_s1_sz;
    logic signed [CW-1:0] r_s1_xa, r_s1_ya, r_s1_za;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_dxb <= DF'(i_cell.data.x_b) - DF'(i_cell.data.x_a);
            r_s1_dyb <= DF'(i_cell.data.y_b) - DF'(i_cell.data.y_a);
            r_s1_dzb <= DF'(i_cell.data.z_b) - DF'(i_cell.data.z_a);
            r_s1_dxc <= DF'(i_cell.data.x_c) - DF'(i_cell.data.x_a);
            r_s1_dyc <= DF'(i_cell.data.y_c) - DF'(i_cell.data.y_a);
            r_s1_dzc <= DF'(i_cell.data.z_c) - DF'(i_cell.data.z_a);
            r_s1_sx  <= SW'(i_cell.data.x_a) + SW'(i_cell.data.x_b) + SW'(i_cell.data.x_c);
            r_s1_sy  <= SW'(i_cell.data.y_a) + SW'(i_cell.data.y_b) + SW'(i_cell.data.y_c);
            r_s1_sz  <= SW'(i_cell.data.z_a) + SW'(i_cell.data.z_b) + SW'(i_cell.data.z_c);
            r_s1_xa  <= i_cell.data.x_a;
            r_s1_ya  <= i_cell.data.y_a;
            r_s1_za  <= i_cell.data.z_a;
        end
    end

    // ---------------- stage 2: cross products, sums divided by three ----------------
    logic signed [PW-1:0] r_s2_pd1, r_s2_pd2, r_s2_px1, r_s2_px2, r_s2_py1, r_s2_py2;
    logic [SW-1:0]        r_s2_qx, r_s2_qy, r_s2_qz;
    logic                 r_s2_nx, r_s2_ny, r_s2_nz;
    logic signed [CW-1:0] r_s2_xa, r_s2_ya, r_s2_za;

    logic [SW-1:0]         n_mx, n_my, n_mz;
    logic [SW+RK-1:0]      n_px, n_py, n_pz;

    always_comb begin
        n_mx = r_s1_sx[SW-1] ? SW'(-r_s1_sx) : SW'(r_s1_sx);
        n_my = r_s1_sy[SW-1] ? SW'(-r_s1_sy) : SW'(r_s1_sy);
        n_mz = r_s1_sz[SW-1] ? SW'(-r_s1_sz) : SW'(r_s1_sz);
        n_px = (SW+RK)'(n_mx) * (SW+RK)'(tcg_pkg::RECIP);
        n_py = (SW+RK)'(n_my) * (SW+RK)'(tcg_pkg::RECIP);
        n_pz = (SW+RK)'(n_mz) * (SW+RK)'(tcg_pkg::RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_pd1 <= PW'(r_s1_dxb) * PW'(r_s1_dyc);
            r_s2_pd2 <= PW'(r_s1_dxc) * PW'(r_s1_dyb);
            r_s2_px1 <= PW'(r_s1_dyc) * PW'(r_s1_dzb);
            r_s2_px2 <= PW'(r_s1_dyb) * PW'(r_s1_dzc);
            r_s2_py1 <= PW'(r_s1_dxb) * PW'(r_s1_dzc);
            r_s2_py2 <= PW'(r_s1_dxc) * PW'(r_s1_dzb);
            r_s2_qx  <= n_px[SW+RK-1:RK];
            r_s2_qy  <= n_py[SW+RK-1:RK];
            r_s2_qz  <= n_pz[SW+RK-1:RK];
            r_s2_nx  <= r_s1_sx[SW-1];
            r_s2_ny  <= r_s1_sy[SW-1];
            r_s2_nz  <= r_s1_sz[SW-1];
            r_s2_xa  <= r_s1_xa;
            r_s2_ya  <= r_s1_ya;
            r_s2_za  <= r_s1_za;
        end
    end

    // ---------------- stage 3: determinant, numerators, magnitudes ----------------
    logic [DW-1:0]        r_s3_ad, r_s3_anx, r_s3_any;
    logic                 r_s3_sd, r_s3_snx, r_s3_sny;
    logic signed [SW-1:0] r_s3_cx, r_s3_cy, r_s3_cz;
    logic signed [CW-1:0] r_s3_xa, r_s3_ya, r_s3_za;

    logic signed [DW-1:0] n_d, n_nx, n_ny;

    always_comb begin
        n_d  = DW'(r_s2_pd1) - DW'(r_s2_pd2);
        n_nx = DW'(r_s2_px1) - DW'(r_s2_px2);
        n_ny = DW'(r_s2_py1) - DW'(r_s2_py2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ad  <= n_d[DW-1]  ? DW'(-n_d)  : DW'(n_d);
            r_s3_anx <= n_nx[DW-1] ? DW'(-n_nx) : DW'(n_nx);
            r_s3_any <= n_ny[DW-1] ? DW'(-n_ny) : DW'(n_ny);
            r_s3_sd  <= n_d[DW-1];
            r_s3_snx <= n_nx[DW-1];
            r_s3_sny <= n_ny[DW-1];
            r_s3_cx  <= r_s2_nx ? SW'(-$signed(r_s2_qx)) : $signed(r_s2_qx);
            r_s3_cy  <= r_s2_ny ? SW'(-$signed(r_s2_qy)) : $signed(r_s2_qy);
            r_s3_cz  <= r_s2_nz ? SW'(-$signed(r_s2_qz)) : $signed(r_s2_qz);
            r_s3_xa  <= r_s2_xa;
            r_s3_ya  <= r_s2_ya;
            r_s3_za  <= r_s2_za;
        end
    end

    // ---------------- slope dividers and side values ----------------
    logic [tcg_pkg::QW-1:0] w_qx, w_qy;
    logic                   w_ovx, w_ovy;

    tcg_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_s3_anx),
        .i_den  (r_s3_ad),
        .o_quot (w_qx),
        .o_ovf  (w_ovx)
    );

    tcg_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_s3_any),
        .i_den  (r_s3_ad),
        .o_quot (w_qy),
        .o_ovf  (w_ovy)
    );

    tcg_pkg::t_side r_sb [ML];
    tcg_pkg::t_side n_sb0;
    logic [127:0]   n_adw;

    always_comb begin
        n_adw       = 128'(r_s3_ad);
        n_sb0.deg   = (r_s3_ad == '0) || (n_adw < 128'(r_limit));
        n_sb0.area  = (n_adw > 128'(tcg_pkg::AREA_MAX)) ? tcg_pkg::AREA_MAX
                                                       : tcg_pkg::AREA_W'(r_s3_ad);
        n_sb0.cx    = n_sb0.deg ? tcg_pkg::sat_coord(SW'(r_s3_xa)) : tcg_pkg::sat_coord(r_s3_cx);
        n_sb0.cy    = n_sb0.deg ? tcg_pkg::sat_coord(SW'(r_s3_ya)) : tcg_pkg::sat_coord(r_s3_cy);
        n_sb0.bm    = n_sb0.deg ? tcg_pkg::sat_coord(SW'(r_s3_za)) : tcg_pkg::sat_coord(r_s3_cz);
        n_sb0.neg_x = r_s3_snx != r_s3_sd;
        n_sb0.neg_y = r_s3_sny != r_s3_sd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_sb0;
            for (int k = 1; k < ML; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- output register ----------------
    tcg_pkg::t_res r_out;
    tcg_pkg::t_res n_out;

    function automatic logic signed [SL-1:0] slope_fmt(input logic [tcg_pkg::QW-1:0] q,
                                                       input logic ovf, input logic neg,
                                                       input logic deg);
        logic signed [SL-1:0] s;
        if (deg) begin
            s = '0;
        end else if (neg) begin
            s = ovf ? {1'b1, {(SL-1){1'b0}}} : SL'(0) - SL'(q);
        end else begin
            s = ovf ? {1'b0, {(SL-1){1'b1}}} : SL'(q);
        end
        slope_fmt = s;
    endfunction

    always_comb begin
        n_out.area       = r_sb[ML-1].area;
        n_out.centroid_x = r_sb[ML-1].cx;
        n_out.centroid_y = r_sb[ML-1].cy;
        n_out.bed_mean   = r_sb[ML-1].bm;
        n_out.degenerate = r_sb[ML-1].deg;
        n_out.slope_x    = slope_fmt(w_qx, w_ovx, r_sb[ML-1].neg_x, r_sb[ML-1].deg);
        n_out.slope_y    = slope_fmt(w_qy, w_ovy, r_sb[ML-1].neg_y, r_sb[ML-1].deg);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_vout;
    assign o_res.data  = r_out;

endmodule
`default_nettype wire
